// ===== hw/rtl/ftbp_pkg.sv =====
`default_nettype none

package ftbp_pkg;

  // Field widths fixed by the item formats
  localparam int ADDR_W        = 32;
  localparam int TOKEN_W       = 16;
  localparam int OUTCOME_W     = 2;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int MAX_TIME_BITS = 48;
  localparam int ELAPSED_W     = TOKEN_W + 1;
  localparam int PRODUCT_W     = ELAPSED_W + TOKEN_W;
  localparam int SUM_W         = PRODUCT_W + 1;

  // Defaults for the top-level parameters
  localparam int DEF_TABLE_SLOTS = 16;
  localparam int DEF_TIME_BITS   = 32;

  // Refill interval is clipped to this many seconds before the multiply
  localparam logic [ELAPSED_W-1:0] ELAPSED_CAP = ELAPSED_W'(1) << TOKEN_W;

  // Item opcodes
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // Result outcomes
  localparam logic [OUTCOME_W-1:0] OUTCOME_ALLOWED    = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_NO_TOKENS  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_TABLE_FULL = 2'd2;
  localparam logic [OUTCOME_W-1:0] OUTCOME_TICK       = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REFILL   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STALE    = 2'd2;

  // Configuration reset values
  localparam logic [TOKEN_W-1:0] RST_CAPACITY = 16'd5;
  localparam logic [TOKEN_W-1:0] RST_REFILL   = 16'd2;
  localparam logic [TOKEN_W-1:0] RST_STALE    = 16'd300;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] flow_address;
  } item_t;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic [TOKEN_W-1:0]   tokens_left;
  } result_t;

  // What the slot table reports for the current request
  typedef struct packed {
    logic                 hit;
    logic                 room;
    logic                 el_zero;
    logic [ELAPSED_W-1:0] el_clip;
    logic [TOKEN_W-1:0]   tokens;
  } slot_view_t;

  // Write-back into the selected slot
  typedef struct packed {
    logic               write;
    logic               claim;
    logic               stamp;
    logic [TOKEN_W-1:0] tokens;
  } update_t;

endpackage

`default_nettype wire

// ===== hw/rtl/per_flow_token_bucket_policer_core.sv =====
// Per-flow token bucket policer. Each transfer on the item channel is either a
// one-second tick or a request from a 32-bit flow address; each yields exactly
// one result transfer, in order. A request is looked up in a table of
// TABLE_SLOTS buckets compared in parallel. A hit refills its bucket by the
// seconds since its last refill times refill_per_second, saturating at
// bucket_capacity, then spends one token if any is left. A miss claims the
// lowest slot that is empty or not refilled for more than stale_seconds,
// with a full bucket; with no such slot the request is denied as table full
// and nothing changes. The block takes one item every cycle while the result
// is not stalled; each item passes through the input register, then the
// result register, and the single pass between them, the slot compare
// followed by the refill multiply-add, sets the clock. Slot valid bits clear
// at reset, so the block is ready right away with no clearing pass. Write
// configuration only while no item is in flight.

`default_nettype none

module per_flow_token_bucket_policer_core import ftbp_pkg::*; #(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
  parameter int TIME_BITS   = DEF_TIME_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  item_t                  item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers
  logic [TOKEN_W-1:0] bucket_capacity;
  logic [TOKEN_W-1:0] refill_per_second;
  logic [TOKEN_W-1:0] stale_seconds;

  // Input register
  logic  held_valid;
  item_t held_item;

  logic [TIME_BITS-1:0] now_seconds;

  logic                 out_ready;
  logic                 advance;
  logic                 go;
  slot_view_t           view;
  update_t              update;
  logic [OUTCOME_W-1:0] outcome;
  logic [TOKEN_W-1:0]   tokens_left;
  result_t              result_next;

  // The result register frees up when empty or when its transfer completes
  assign out_ready  = !result_valid || !result_stall;
  assign advance    = held_valid && out_ready;
  assign item_stall = held_valid && !out_ready;
  assign go         = advance && (held_item.op == OP_REQUEST);

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_capacity   <= RST_CAPACITY;
      refill_per_second <= RST_REFILL;
      stale_seconds     <= RST_STALE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CAPACITY: bucket_capacity   <= cfg_data;
        REG_REFILL:   refill_per_second <= cfg_data;
        REG_STALE:    stale_seconds     <= cfg_data;
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // Hold the item until the result register can take its outcome
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held_item <= item;
    end
  end

  // Advance the seconds counter on each tick; it wraps
  always_ff @(posedge clk) begin
    if (rst) begin
      now_seconds <= '0;
    end else if (advance && (held_item.op == OP_TICK)) begin
      now_seconds <= now_seconds + TIME_BITS'(1);
    end
  end

  ftbp_slot_table #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .TIME_BITS   (TIME_BITS)
  ) u_slot_table (
    .clk           (clk),
    .rst           (rst),
    .flow_address  (held_item.flow_address),
    .now_seconds   (now_seconds),
    .stale_seconds (stale_seconds),
    .update        (update),
    .view          (view)
  );

  ftbp_refill u_refill (
    .go                (go),
    .view              (view),
    .bucket_capacity   (bucket_capacity),
    .refill_per_second (refill_per_second),
    .update            (update),
    .outcome           (outcome),
    .tokens_left       (tokens_left)
  );

  always_comb begin
    if (held_item.op == OP_TICK) begin
      result_next.outcome     = OUTCOME_TICK;
      result_next.tokens_left = '0;
    end else begin
      result_next.outcome     = outcome;
      result_next.tokens_left = tokens_left;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_ready) begin
      result_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ftbp_slot_table.sv =====
`default_nettype none

module ftbp_slot_table import ftbp_pkg::*; #(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
  parameter int TIME_BITS   = DEF_TIME_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [ADDR_W-1:0]    flow_address,
  input  logic [TIME_BITS-1:0] now_seconds,
  input  logic [TOKEN_W-1:0]   stale_seconds,
  input  update_t              update,
  output slot_view_t           view
);

  logic [TABLE_SLOTS-1:0] slot_valid;
  logic [ADDR_W-1:0]      slot_address     [TABLE_SLOTS];
  logic [TOKEN_W-1:0]     slot_tokens      [TABLE_SLOTS];
  logic [TIME_BITS-1:0]   slot_last_refill [TABLE_SLOTS];

  logic [TIME_BITS-1:0]     elapsed [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0]   match;
  logic [TABLE_SLOTS-1:0]   free;
  logic [TABLE_SLOTS-1:0]   hit_oh;
  logic [TABLE_SLOTS-1:0]   free_oh;
  logic [TABLE_SLOTS-1:0]   target;
  logic [TIME_BITS-1:0]     hit_elapsed;
  logic [TOKEN_W-1:0]       hit_tokens;
  logic [MAX_TIME_BITS-1:0] el_wide;

  // Compare every slot in parallel
  always_comb begin
    for (int s = 0; s < TABLE_SLOTS; s++) begin
      elapsed[s] = now_seconds - slot_last_refill[s];
      match[s]   = slot_valid[s] && (slot_address[s] == flow_address);
      free[s]    = !slot_valid[s] ||
                   (!match[s] && (MAX_TIME_BITS'(elapsed[s]) > MAX_TIME_BITS'(stale_seconds)));
    end
  end

  // Lowest set bit wins
  assign hit_oh  = match & (~match + TABLE_SLOTS'(1));
  assign free_oh = free & (~free + TABLE_SLOTS'(1));
  assign target  = (|match) ? hit_oh : free_oh;

  always_comb begin
    hit_elapsed = '0;
    hit_tokens  = '0;
    for (int s = 0; s < TABLE_SLOTS; s++) begin
      if (hit_oh[s]) begin
        hit_elapsed = hit_elapsed | elapsed[s];
        hit_tokens  = hit_tokens | slot_tokens[s];
      end
    end
  end

  assign el_wide      = MAX_TIME_BITS'(hit_elapsed);
  assign view.hit     = |match;
  assign view.room    = |free;
  assign view.el_zero = (hit_elapsed == '0);
  assign view.el_clip = (|el_wide[MAX_TIME_BITS-1:TOKEN_W]) ? ELAPSED_CAP
                        : {1'b0, el_wide[TOKEN_W-1:0]};
  assign view.tokens  = hit_tokens;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (update.write && update.claim) begin
      slot_valid <= slot_valid | target;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < TABLE_SLOTS; s++) begin
      if (update.write && target[s]) begin
        slot_tokens[s] <= update.tokens;
        if (update.claim) begin
          slot_address[s] <= flow_address;
        end
        if (update.stamp) begin
          slot_last_refill[s] <= now_seconds;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ftbp_refill.sv =====
`default_nettype none

module ftbp_refill import ftbp_pkg::*; (
  input  logic                 go,
  input  slot_view_t           view,
  input  logic [TOKEN_W-1:0]   bucket_capacity,
  input  logic [TOKEN_W-1:0]   refill_per_second,
  output update_t              update,
  output logic [OUTCOME_W-1:0] outcome,
  output logic [TOKEN_W-1:0]   tokens_left
);

  logic [PRODUCT_W-1:0] product;
  logic [SUM_W-1:0]     sum;
  logic [TOKEN_W-1:0]   refilled;
  logic [TOKEN_W-1:0]   base;
  logic                 spend;
  logic [TOKEN_W-1:0]   left;

  assign product  = PRODUCT_W'(view.el_clip) * PRODUCT_W'(refill_per_second);
  assign sum      = SUM_W'(view.tokens) + SUM_W'(product);
  assign refilled = (sum > SUM_W'(bucket_capacity)) ? bucket_capacity : sum[TOKEN_W-1:0];

  // A new bucket starts full; a hit with no time gone keeps its count
  assign base  = !view.hit ? bucket_capacity : (view.el_zero ? view.tokens : refilled);
  assign spend = (base != '0);
  assign left  = base - TOKEN_W'(spend);

  assign update.write  = go && (view.hit || view.room);
  assign update.claim  = go && !view.hit && view.room;
  assign update.stamp  = go && (view.hit ? !view.el_zero : view.room);
  assign update.tokens = left;

  always_comb begin
    if (!view.hit && !view.room) begin
      outcome     = OUTCOME_TABLE_FULL;
      tokens_left = '0;
    end else begin
      outcome     = spend ? OUTCOME_ALLOWED : OUTCOME_NO_TOKENS;
      tokens_left = left;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ftbp_checker.sv =====
`default_nettype none

module ftbp_checker import ftbp_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input item_t   item,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // A stalled item holds
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_stall |=> item_valid && $stable(item))
    else $error("stalled item changed");

  // Backpressure on items only comes from a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("item stalled with no result waiting");

  // Only an allowed request reports a nonzero count
  a_zero_tokens: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.outcome != OUTCOME_ALLOWED) |-> result.tokens_left == '0)
    else $error("tokens reported on a denied request or tick");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind per_flow_token_bucket_policer_core ftbp_checker u_checker (.*);

`default_nettype wire
